>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WTA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Condition must never be true outside reset.
`define WTA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> src/wta_pkg.sv
package wta_pkg;

  localparam int X_W      = 32;          // sample abscissa
  localparam int Y_W      = 24;          // sample ordinate, signed
  localparam int HW_W     = 31;          // window half width
  localparam int CFG_W    = 32;          // widest configuration register
  localparam int CFG_IDX_W = 1;
  localparam int E_W      = X_W + 2;     // window edges, signed
  localparam int DX_W     = E_W + 1;     // trapezoid width, signed
  localparam int SY_W     = Y_W + 1;     // edge ordinate / ordinate difference
  localparam int SS_W     = SY_W + 1;    // sum of two ordinates
  localparam int QUO_W    = Y_W;         // interpolation quotient
  localparam int PROD_W   = X_W + QUO_W; // interpolation product
  localparam int CNT_W    = $clog2(QUO_W);
  localparam int TERM_W   = DX_W + SS_W;
  localparam int AREA_W   = 64;
  localparam int STATUS_W = 3;

  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CENTER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LEFT_FAIL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RIGHT_FAIL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic                enter;   // interpolate the left edge and restart the sum
    logic                add;     // add the trapezoid up to this sample
    logic                close;   // interpolate the right edge, add, report
    logic                fail;    // report a failure status with a zero area
    logic [STATUS_W-1:0] status;
    logic                hw_zero;
    logic [E_W-1:0]      left;
    logic [E_W-1:0]      right;
    logic [X_W-1:0]      prev_x;
    logic [Y_W-1:0]      prev_y;
    logic [X_W-1:0]      x;
    logic [Y_W-1:0]      y;
  } wta_cmd_t;

endpackage

>>> src/windowed_trapezoid_area.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_sample_x, in_sample_y, in_last_sample
// out       out_valid / out_ready  out_area, out_status
// cfg       cfg_we                 cfg_index, cfg_data
//
// The front takes one sample per cycle while the 4-entry command queue has room.
// The back runs an inside sample through dispatch, multiply and accumulate; each
// window edge adds a multiply, 24 divide steps and a finish, and a report adds an
// output register load. Samples before the window or after the report stay in the
// front, save the last sample of an unreported trace. Reset is synchronous and
// active low; it clears the control state and sets the window to center 0, half
// width 1. A stalled output stalls the back, and through the queue the front.

module windowed_trapezoid_area import wta_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [X_W-1:0]            in_sample_x,
  input  logic signed [Y_W-1:0]     in_sample_y,
  input  logic                      in_last_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [AREA_W-1:0]  out_area,
  output logic [STATUS_W-1:0]       out_status
);

  wta_cmd_t front_cmd, back_cmd;
  logic     front_valid, front_ready;
  logic     back_valid, back_ready;

  wta_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .in_last_sample (in_last_sample),
    .cmd_valid      (front_valid),
    .cmd_ready      (front_ready),
    .cmd            (front_cmd)
  );

  wta_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  wta_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .cmd        (back_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_area   (out_area),
    .out_status (out_status)
  );

endmodule

>>> src/wta_queue.sv
`include "assert_macros.svh"

module wta_queue import wta_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  wta_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output wta_cmd_t pop_data
);

  wta_cmd_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `WTA_ASSERT_NEVER(a_q_count_bound, clk, rst_n, count_r > Q_CNT_W'(Q_DEPTH))

endmodule

>>> src/wta_front.sv
`include "assert_macros.svh"

module wta_front import wta_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [X_W-1:0]         in_sample_x,
  input  logic signed [Y_W-1:0]  in_sample_y,
  input  logic                   in_last_sample,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output wta_cmd_t               cmd
);

  typedef enum logic [3:0] {
    PH_BEFORE = 4'b0001,
    PH_INSIDE = 4'b0010,
    PH_LFAIL  = 4'b0100,
    PH_DONE   = 4'b1000
  } wta_phase_t;

  logic [X_W-1:0]   center_r;
  logic [HW_W-1:0]  half_r;
  wta_phase_t       phase_r, phase_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [X_W-1:0]   prev_x_r;
  logic [Y_W-1:0]   prev_y_r;

  logic signed [E_W-1:0] left, right, xs;
  logic             accept, ge_left, enter, to_lfail, in_win, add, close, fail;
  logic [STATUS_W-1:0] fail_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      half_r   <= HW_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_CENTER: center_r <= cfg_data[X_W-1:0];
        CFG_IDX_HALF:   half_r   <= cfg_data[HW_W-1:0];
        default: ;
      endcase
    end
  end

  assign left  = $signed(E_W'(center_r)) - $signed(E_W'(half_r));
  assign right = $signed(E_W'(center_r)) + $signed(E_W'(half_r));
  assign xs    = $signed(E_W'(in_sample_x));

  // Window bookkeeping is compares only: full rate while the queue has room.
  assign ge_left  = (xs >= left);
  assign enter    = (phase_r == PH_BEFORE) && ge_left && have_prev_r;
  assign to_lfail = (phase_r == PH_BEFORE) && ge_left && !have_prev_r;
  assign in_win   = (phase_r == PH_INSIDE) || enter;
  assign add      = in_win && (xs < right);
  assign close    = in_win && !(xs < right);

  always_comb begin
    phase_nxt = phase_r;
    if (close) begin
      phase_nxt = PH_DONE;
    end else if (enter) begin
      phase_nxt = PH_INSIDE;
    end else if (to_lfail) begin
      phase_nxt = PH_LFAIL;
    end
  end

  assign fail = in_last_sample && !close && (phase_nxt != PH_DONE);

  always_comb begin
    if (!have_prev_r) begin
      fail_status = ST_TOO_FEW;
    end else if (phase_nxt == PH_LFAIL) begin
      fail_status = ST_LEFT_FAIL;
    end else begin
      fail_status = ST_RIGHT_FAIL;
    end
  end

  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = in_valid && (enter || add || close || fail);

  assign cmd.enter   = enter;
  assign cmd.add     = add;
  assign cmd.close   = close;
  assign cmd.fail    = fail;
  assign cmd.status  = fail_status;
  assign cmd.hw_zero = (half_r == '0);
  assign cmd.left    = left;
  assign cmd.right   = right;
  assign cmd.prev_x  = prev_x_r;
  assign cmd.prev_y  = prev_y_r;
  assign cmd.x       = in_sample_x;
  assign cmd.y       = in_sample_y;

  // The last sample of a trace puts the trace state back to its idle values.
  assign have_prev_nxt = !in_last_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BEFORE;
      have_prev_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= in_last_sample ? PH_BEFORE : phase_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x_r <= in_sample_x;
      prev_y_r <= in_sample_y;
    end
  end

  `WTA_ASSERT_IMP(a_front_inside_has_prev, clk, rst_n, phase_r == PH_INSIDE, have_prev_r)

endmodule

>>> src/wta_back.sv
`include "assert_macros.svh"

module wta_back import wta_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  wta_cmd_t                   cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [AREA_W-1:0]   out_area,
  output logic [STATUS_W-1:0]        out_status
);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_EMUL = 7'b0000010,
    B_EDIV = 7'b0000100,
    B_EFIN = 7'b0001000,
    B_TMUL = 7'b0010000,
    B_TACC = 7'b0100000,
    B_EMIT = 7'b1000000
  } wta_bstate_t;

  wta_bstate_t               state_r, state_nxt;
  wta_cmd_t                  cmd_r;
  logic                      edge_right_r;
  logic                      fault_r;
  logic signed [AREA_W-1:0]  area_r;
  logic signed [E_W-1:0]     seg_x_r;
  logic signed [SY_W-1:0]    seg_y_r;
  logic signed [SY_W-1:0]    ey_r;
  logic [X_W-1:0]            rem_r;
  logic [QUO_W-1:0]          quo_r;
  logic [X_W-1:0]            dvs_r;
  logic                      neg_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [TERM_W-1:0]  term_r;
  logic                      out_valid_r;
  logic signed [AREA_W-1:0]  out_area_r;
  logic [STATUS_W-1:0]       out_status_r;

  logic signed [E_W-1:0]     e_sel, x0s, x1s, e_off, xb;
  logic                      edge_bad;
  logic signed [SY_W-1:0]    ydiff, ymag_full, y0e, qs, ey, yb;
  logic [Y_W-1:0]            ymag;
  logic [PROD_W-1:0]         prod;
  logic [X_W:0]              rem_sh, dvs_ext;
  logic                      take;
  logic signed [DX_W-1:0]    dx;
  logic signed [SS_W-1:0]    ysum;
  logic signed [TERM_W-1:0]  term;
  logic signed [AREA_W:0]    sum;
  logic                      ovf;
  logic signed [AREA_W-1:0]  area_rnd, area_half;
  logic                      emit_go, bad;

  // Edge interpolation: y0 + (e - x0) * (y1 - y0) / (x1 - x0).
  assign e_sel     = edge_right_r ? $signed(cmd_r.right) : $signed(cmd_r.left);
  assign x0s       = $signed(E_W'(cmd_r.prev_x));
  assign x1s       = $signed(E_W'(cmd_r.x));
  assign edge_bad  = !(x0s < e_sel) || !(e_sel <= x1s);
  assign e_off     = e_sel - x0s;
  assign ydiff     = $signed({cmd_r.y[Y_W-1], cmd_r.y}) -
                     $signed({cmd_r.prev_y[Y_W-1], cmd_r.prev_y});
  assign ymag_full = ydiff[SY_W-1] ? -ydiff : ydiff;
  assign ymag      = ymag_full[Y_W-1:0];
  assign prod      = PROD_W'(e_off[X_W-1:0]) * PROD_W'(ymag);

  // The quotient is never larger than |y1 - y0|, so only its low QUO_W bits
  // are developed and the upper product bits seed the remainder.
  assign rem_sh  = {rem_r, quo_r[QUO_W-1]};
  assign dvs_ext = {1'b0, dvs_r};
  assign take    = (rem_sh >= dvs_ext);

  assign y0e = $signed({cmd_r.prev_y[Y_W-1], cmd_r.prev_y});
  assign qs  = $signed({1'b0, quo_r});
  assign ey  = neg_r ? (y0e - qs) : (y0e + qs);

  // Doubled trapezoid term.
  assign xb   = cmd_r.close ? $signed(cmd_r.right) : x1s;
  assign yb   = cmd_r.close ? ey_r : $signed({cmd_r.y[Y_W-1], cmd_r.y});
  assign dx   = $signed({xb[E_W-1], xb}) - $signed({seg_x_r[E_W-1], seg_x_r});
  assign ysum = $signed({seg_y_r[SY_W-1], seg_y_r}) + $signed({yb[SY_W-1], yb});
  assign term = $signed(TERM_W'(dx)) * $signed(TERM_W'(ysum));

  assign sum = $signed({area_r[AREA_W-1], area_r}) +
               $signed({{(AREA_W + 1 - TERM_W){term_r[TERM_W-1]}}, term_r});
  assign ovf = sum[AREA_W] ^ sum[AREA_W-1];

  // Halve with truncation toward zero.
  assign area_rnd  = area_r + $signed(AREA_W'(area_r[AREA_W-1]));
  assign area_half = area_rnd >>> 1;

  assign emit_go   = (state_r == B_EMIT) && (!out_valid_r || out_ready);
  assign bad       = fault_r || cmd_r.hw_zero;
  assign cmd_ready = (state_r == B_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.enter || cmd.close) begin
            state_nxt = B_EMUL;
          end else if (cmd.add) begin
            state_nxt = B_TMUL;
          end else begin
            state_nxt = B_EMIT;
          end
        end
      end
      B_EMUL: state_nxt = edge_bad ? B_EFIN : B_EDIV;
      B_EDIV: begin
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          state_nxt = B_EFIN;
        end
      end
      B_EFIN: state_nxt = (!edge_right_r && cmd_r.close) ? B_EMUL : B_TMUL;
      B_TMUL: state_nxt = B_TACC;
      // A trace that ends inside the window still owes a failure report.
      B_TACC: state_nxt = (cmd_r.close || cmd_r.fail) ? B_EMIT : B_IDLE;
      B_EMIT: begin
        if (emit_go) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_r        <= cmd;
          edge_right_r <= !cmd.enter;
          if (cmd.enter) begin
            area_r  <= '0;
            fault_r <= 1'b0;
          end
        end
      end
      B_EMUL: begin
        cnt_r <= '0;
        if (edge_bad) begin
          // The samples do not straddle the edge; the result is void anyway.
          fault_r <= 1'b1;
          neg_r   <= 1'b0;
          quo_r   <= '0;
        end else begin
          rem_r <= prod[PROD_W-1:QUO_W];
          quo_r <= prod[QUO_W-1:0];
          dvs_r <= cmd_r.x - cmd_r.prev_x;
          neg_r <= ydiff[SY_W-1];
        end
      end
      B_EDIV: begin
        rem_r <= take ? rem_sh[X_W-1:0] - dvs_r : rem_sh[X_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], take};
        cnt_r <= cnt_r + 1'b1;
      end
      B_EFIN: begin
        ey_r <= ey;
        if (!edge_right_r) begin
          seg_x_r      <= $signed(cmd_r.left);
          seg_y_r      <= ey;
          edge_right_r <= 1'b1;
        end
      end
      B_TMUL: term_r <= term;
      B_TACC: begin
        if (ovf) begin
          fault_r <= 1'b1;
        end else begin
          area_r <= sum[AREA_W-1:0];
        end
        if (!cmd_r.close) begin
          seg_x_r <= x1s;
          seg_y_r <= $signed({cmd_r.y[Y_W-1], cmd_r.y});
        end
      end
      B_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (cmd_r.fail) begin
        out_area_r   <= '0;
        out_status_r <= cmd_r.status;
      end else begin
        out_area_r   <= bad ? '0 : area_half;
        out_status_r <= bad ? ST_SATURATED : ST_OK;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_area   = out_area_r;
  assign out_status = out_status_r;

  `WTA_ASSERT_IMP(a_back_rem_below_divisor, clk, rst_n, state_r == B_EDIV, rem_r < dvs_r)
  `WTA_ASSERT_IMP(a_back_emit_has_report, clk, rst_n, state_r == B_EMIT,
                  cmd_r.close || cmd_r.fail)

endmodule

>>> tb/sv/windowed_trapezoid_area_tb.sv
module windowed_trapezoid_area_tb;
  import wta_pkg::*;

  localparam int     STALL_LIMIT   = 4000;
  localparam int     SETTLE_CYCLES = 300;
  localparam int     RANDOM_ITEMS  = 900;
  localparam int     TRACES_PER_WINDOW = 16;
  localparam longint X_MAX      = 64'h0000_0000_FFFF_FFFF;
  localparam longint AREA_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint AREA_MIN   = -AREA_MAX - 1;
  localparam longint unsigned AREA_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {BEFORE_WINDOW, IN_WINDOW, LEFT_FAILED, REPORTED} trace_phase_t;

  typedef struct {
    longint              area;
    logic [STATUS_W-1:0] status;
  } area_result_t;

  // Tracks one trace at a time and queues the window area that each accepted
  // sample is due to produce.
  class area_scoreboard;
    logic [X_W-1:0]  center;
    logic [HW_W-1:0] win_half;
    longint          prev_x, prev_y, area_sum, seg_x, seg_y;
    bit              have_prev, fault;
    trace_phase_t    phase;
    area_result_t    pending_areas[$];
    int              failures, results_checked;

    function new();
      center = '0;
      win_half = 1;
      failures = 0;
      results_checked = 0;
      clear_trace();
    endfunction

    function void clear_trace();
      prev_x = 0;
      prev_y = 0;
      have_prev = 0;
      phase = BEFORE_WINDOW;
      area_sum = 0;
      seg_x = 0;
      seg_y = 0;
      fault = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_IDX_CENTER) center = data[X_W-1:0];
      else if (idx == CFG_IDX_HALF) win_half = data[HW_W-1:0];
    endfunction

    // Ordinate at abscissa e on the line through the two neighbors, with the
    // quotient truncated toward zero.
    function longint edge_ordinate(longint x0, longint y0, longint x1, longint y1, longint e);
      longint       diff, gap, run, q;
      logic [127:0] num, den;
      if (!(x0 < e) || !(e <= x1)) begin
        fault = 1;
        return y0;
      end
      diff = y1 - y0;
      gap = e - x0;
      run = x1 - x0;
      num = (diff < 0) ? -diff : diff;
      num = num * gap;
      den = run;
      q = num / den;
      return (diff < 0) ? y0 - q : y0 + q;
    endfunction

    // Adds the doubled trapezoid from the current segment start to (xb, yb).
    function void add_slice(longint xb, longint yb);
      longint          dx, s, t;
      longint unsigned mdx, ms;
      dx = xb - seg_x;
      s = seg_y + yb;
      mdx = (dx < 0) ? -dx : dx;
      ms = (s < 0) ? -s : s;
      if (ms != 0 && mdx > AREA_MAX_U / ms) begin
        fault = 1;
        return;
      end
      t = mdx * ms;
      if ((dx < 0) != (s < 0)) t = -t;
      if ((t > 0 && area_sum > AREA_MAX - t) || (t < 0 && area_sum < AREA_MIN - t)) begin
        fault = 1;
        return;
      end
      area_sum += t;
    endfunction

    function void note_sample(logic [X_W-1:0] xs, logic signed [Y_W-1:0] ys, logic is_last);
      longint       x, y, left, right;
      bit           had_prev, closed;
      area_result_t r;
      x = xs;
      y = ys;
      left = center;
      left = left - win_half;
      right = center;
      right = right + win_half;
      had_prev = have_prev;
      closed = 0;
      if (phase == BEFORE_WINDOW && x >= left) begin
        if (!had_prev) begin
          phase = LEFT_FAILED;
        end else begin
          seg_x = left;
          seg_y = edge_ordinate(prev_x, prev_y, x, y, left);
          area_sum = 0;
          phase = IN_WINDOW;
        end
      end
      if (phase == IN_WINDOW) begin
        if (x < right) begin
          add_slice(x, y);
          seg_x = x;
          seg_y = y;
        end else begin
          add_slice(right, edge_ordinate(prev_x, prev_y, x, y, right));
          phase = REPORTED;
          closed = 1;
        end
      end
      prev_x = x;
      prev_y = y;
      have_prev = 1;
      if (closed) begin
        if (fault || win_half == 0) begin
          r.area = 0;
          r.status = ST_SATURATED;
        end else begin
          r.area = area_sum / 2;
          r.status = ST_OK;
        end
        pending_areas.push_back(r);
      end
      if (is_last) begin
        if (!closed && phase != REPORTED) begin
          r.area = 0;
          if (!had_prev) r.status = ST_TOO_FEW;
          else if (phase == LEFT_FAILED) r.status = ST_LEFT_FAIL;
          else r.status = ST_RIGHT_FAIL;
          pending_areas.push_back(r);
        end
        clear_trace();
      end
    endfunction

    function void check_area(logic signed [AREA_W-1:0] area, logic [STATUS_W-1:0] status);
      area_result_t want;
      if (pending_areas.size() == 0) begin
        $error("unexpected result: area %0d, status %0d", area, status);
        failures++;
        return;
      end
      want = pending_areas.pop_front();
      results_checked++;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        failures++;
      end
      if (area !== want.area) begin
        $error("area: expected %0d, got %0d", want.area, area);
        failures++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [X_W-1:0]           in_sample_x;
  logic signed [Y_W-1:0]    in_sample_y;
  logic                     in_last_sample;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [AREA_W-1:0] out_area;
  logic [STATUS_W-1:0]      out_status;

  area_scoreboard  sb = new();
  int              send_idle_pct;
  int              recv_idle_pct;
  int              samples_sent;
  int              random_items;
  int              windows_used;
  logic [X_W-1:0]  cur_center;
  logic [HW_W-1:0] cur_half;

  windowed_trapezoid_area u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_area       (out_area),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random back-pressure, each transfer checked against the oldest
  // expected area.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_area(out_area, out_status);
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_sample(input logic [X_W-1:0] x, input logic signed [Y_W-1:0] y,
                             input logic is_last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_x    <= x;
    in_sample_y    <= y;
    in_last_sample <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(x, y, is_last);
    samples_sent++;
  endtask

  // Holds the input off until every expected area is back, then lets samples
  // that produce no result work through the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_areas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [X_W-1:0] center, input logic [HW_W-1:0] win_half);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_CENTER;
    cfg_data  <= center;
    @(posedge clk);
    cfg_index <= CFG_IDX_HALF;
    cfg_data  <= {1'b0, win_half};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_IDX_CENTER, center);
    sb.write_reg(CFG_IDX_HALF, {1'b0, win_half});
    cur_center = center;
    cur_half = win_half;
    windows_used++;
  endtask

  task automatic pick_window();
    logic [X_W-1:0]  c;
    logic [HW_W-1:0] h;
    c = $urandom();
    h = HW_W'($urandom_range(32'd1 << $urandom_range(30, 0), 1));
    case ($urandom_range(7, 0))
      0: c = '0;
      1: begin
        c = '1;
        h = '1;
      end
      2: h = 1;
      3: h = '1;
      default: ;
    endcase
    set_window(c, h);
  endtask

  // Alternating sweeps across a window of nearly full width, arranged so that
  // every trapezoid adds with the same sign, until the doubled sum overflows.
  task automatic send_saturating_trace();
    int i;
    wait_idle();
    set_window(32'h8000_0000, 31'h7FFF_FFFF);
    send_sample(32'd0, 8388607, 1'b0);
    for (i = 0; i < 80; i++) begin
      send_sample(32'd1, 8388607, 1'b0);
      send_sample(32'hFFFF_FFFE, 8388607, 1'b0);
      send_sample(32'hFFFF_FFFE, -8388608, 1'b0);
      send_sample(32'd1, -8388608, 1'b0);
    end
    send_sample(32'hFFFF_FFFF, 0, 1'b1);
  endtask

  // Mostly a rising sweep that starts just left of the window, with the odd
  // step backwards; one trace in ten has scattered abscissas.
  task automatic send_random_trace();
    int                    n, i, scattered;
    longint                left, span, stride, x;
    logic signed [Y_W-1:0] y;
    n = ($urandom_range(19, 0) == 0) ? 1 : $urandom_range(12, 2);
    scattered = ($urandom_range(9, 0) == 0);
    left = cur_center;
    left = left - cur_half;
    span = (cur_half == 0) ? 1 : cur_half;
    x = left - 1 - longint'($urandom_range(32'(span), 0));
    stride = (6 * span) / n + 1;
    if (stride > X_MAX) stride = X_MAX;
    for (i = 0; i < n; i++) begin
      if (scattered) begin
        x = $urandom();
      end else if (i > 0) begin
        if ($urandom_range(9, 0) == 0) x = x - longint'($urandom_range(32'(stride / 4), 0));
        else x = x + longint'($urandom_range(32'(stride), 0));
      end
      if (x < 0) x = 0;
      if (x > X_MAX) x = X_MAX;
      case ($urandom_range(3, 0))
        0: y = $urandom_range(1, 0) ? 24'sh7F_FFFF : 24'sh80_0000;
        1: y = Y_W'(int'($urandom_range(200, 0)) - 100);
        default: y = Y_W'($urandom());
      endcase
      send_sample(x[X_W-1:0], y, i == n - 1);
    end
    random_items += n;
  endtask

  initial begin
    int ph, traces, phase_end;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_IDX_CENTER;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_sample_x    <= '0;
    in_sample_y    <= '0;
    in_last_sample <= 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 51;
    samples_sent = 0;
    random_items = 0;
    windows_used = 0;
    cur_center = '0;
    cur_half = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Window [900, 1100].
    set_window(32'd1000, 31'd100);
    // Enter, two inside, close with both ordinate extremes.
    send_sample(32'd800, 1000, 1'b0);
    send_sample(32'd950, -2000, 1'b0);
    send_sample(32'd1050, 8388607, 1'b0);
    send_sample(32'd1200, -8388608, 1'b1);
    // Single-sample trace.
    send_sample(32'd5, 3, 1'b1);
    // First sample already inside the window.
    send_sample(32'd950, 1, 1'b0);
    send_sample(32'd1300, 3, 1'b1);
    // Trace ends inside the window.
    send_sample(32'd0, 0, 1'b0);
    send_sample(32'd1000, 5, 1'b0);
    send_sample(32'd1050, 6, 1'b1);
    // A step backwards inside, then a close exactly on the right edge.
    send_sample(32'd100, 7, 1'b0);
    send_sample(32'd1000, -5, 1'b0);
    send_sample(32'd920, 100, 1'b0);
    send_sample(32'd1100, 50, 1'b1);
    // Samples after the result are ignored up to the end of the trace.
    send_sample(32'd0, 1, 1'b0);
    send_sample(32'd2000, 2, 1'b0);
    send_sample(32'd3000, 3, 1'b0);
    send_sample(32'd0, 4, 1'b1);
    // Window moves mid-trace so the left edge falls behind the last sample.
    send_sample(32'd850, 9, 1'b0);
    wait_idle();
    set_window(32'd800, 31'd100);
    send_sample(32'd900, 1, 1'b0);
    send_sample(32'd2000, 2, 1'b1);
    // Zero half width.
    wait_idle();
    set_window(32'd500, 31'd0);
    send_sample(32'd0, 10, 1'b0);
    send_sample(32'd500, 20, 1'b0);
    send_sample(32'd600, 30, 1'b1);
    // Widest window at the top of the range never closes.
    wait_idle();
    set_window(32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_sample(32'd0, -8388608, 1'b0);
    send_sample(32'hFFFF_FFFF, 8388607, 1'b1);
    // Left edge below zero.
    wait_idle();
    set_window(32'd0, 31'h7FFF_FFFF);
    send_sample(32'd0, 5, 1'b0);
    send_sample(32'd7, 5, 1'b1);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 0) send_saturating_trace();
      traces = 0;
      phase_end = random_items + RANDOM_ITEMS / 3;
      while (random_items < phase_end) begin
        if (traces % TRACES_PER_WINDOW == 0) begin
          wait_idle();
          pick_window();
        end
        send_random_trace();
        traces++;
      end
    end

    wait_idle();
    $display("Sent %0d samples over %0d window settings; %0d window areas checked.",
             samples_sent, windows_used, sb.results_checked);
    $display("Traces covered closing, both edge failures, short traces and an overflowing sum.");
    if (sb.failures == 0 && sb.pending_areas.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> windowed_trapezoid_area.f
+incdir+src
src/wta_pkg.sv
src/wta_queue.sv
src/wta_front.sv
src/wta_back.sv
src/windowed_trapezoid_area.sv
tb/sv/windowed_trapezoid_area_tb.sv
